// File: sv/cln_pkg.sv
// Shared types, codes and step tables for the character LCD nibble sequencer.
package cln_pkg;

	localparam int unsigned WaitW = 16;
	localparam int unsigned StepIdxW = 4;
	localparam int unsigned CfgIdxW = 3;

	localparam logic [WaitW-1:0] FOUR_BIT_WAIT_US = 16'd5000;

	localparam logic [StepIdxW-1:0] INIT_LAST_IDX = 4'd12;
	localparam logic [StepIdxW-1:0] BYTE_LAST_IDX = 4'd1;

	typedef enum logic [2:0] {
		ACT_INIT   = 3'd0,
		ACT_DATA   = 3'd1,
		ACT_CMD    = 3'd2,
		ACT_CLEAR  = 3'd3,
		ACT_HOME   = 3'd4,
		ACT_CURSOR = 3'd5,
		ACT_GLYPH  = 3'd6
	} action_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_BOOT   = 3'd0,
		CFG_RST1   = 3'd1,
		CFG_RST2   = 3'd2,
		CFG_RST3   = 3'd3,
		CFG_CMD    = 3'd4,
		CFG_DATA   = 3'd5,
		CFG_CLEAR  = 3'd6,
		CFG_HOME   = 3'd7
	} cfg_idx_t;

	localparam logic [WaitW-1:0] RST_BOOT  = 16'd15000;
	localparam logic [WaitW-1:0] RST_RST1  = 16'd5000;
	localparam logic [WaitW-1:0] RST_RST2  = 16'd1000;
	localparam logic [WaitW-1:0] RST_RST3  = 16'd1000;
	localparam logic [WaitW-1:0] RST_CMD   = 16'd42;
	localparam logic [WaitW-1:0] RST_DATA  = 16'd46;
	localparam logic [WaitW-1:0] RST_CLEAR = 16'd2000;
	localparam logic [WaitW-1:0] RST_HOME  = 16'd2000;

	localparam logic [7:0] CMD_CLEAR_CODE = 8'h01;
	localparam logic [7:0] CMD_HOME_CODE  = 8'h02;
	localparam logic [7:0] CMD_DDRAM      = 8'h80;
	localparam logic [7:0] CMD_CGRAM      = 8'h40;

	// Wait source of one step
	typedef enum logic [3:0] {
		WS_ZERO,
		WS_BOOT,
		WS_RST1,
		WS_RST2,
		WS_RST3,
		WS_FOUR,
		WS_CMD,
		WS_DATA,
		WS_CMD_CLEAR,
		WS_CMD_HOME
	} wsel_t;

	typedef struct packed {
		logic       strobe;
		logic [3:0] nibble;
		wsel_t      wsel;
	} init_step_t;

	// Controller to datapath
	typedef struct packed {
		logic                load;
		logic                emit;
		logic [StepIdxW-1:0] idx;
		logic                last;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic                none;
		logic [StepIdxW-1:0] last_idx;
		logic                out_busy;
	} dp_stat_t;

	function automatic logic [7:0] line_addr(input logic [1:0] row);
		logic [7:0] a;
		begin
			unique case (row)
				2'd0: a = 8'h00;
				2'd1: a = 8'h40;
				2'd2: a = 8'h10;
				default: a = 8'h50;
			endcase
			return a;
		end
	endfunction

	function automatic init_step_t init_step(input logic [StepIdxW-1:0] idx);
		init_step_t s;
		begin
			unique case (idx)
				4'd0:  s = '{strobe: 1'b0, nibble: 4'h0, wsel: WS_BOOT};
				4'd1:  s = '{strobe: 1'b1, nibble: 4'h3, wsel: WS_RST1};
				4'd2:  s = '{strobe: 1'b1, nibble: 4'h3, wsel: WS_RST2};
				4'd3:  s = '{strobe: 1'b1, nibble: 4'h3, wsel: WS_RST3};
				4'd4:  s = '{strobe: 1'b1, nibble: 4'h2, wsel: WS_FOUR};
				4'd5:  s = '{strobe: 1'b1, nibble: 4'h2, wsel: WS_ZERO};
				4'd6:  s = '{strobe: 1'b1, nibble: 4'h8, wsel: WS_CMD};
				4'd7:  s = '{strobe: 1'b1, nibble: 4'h0, wsel: WS_ZERO};
				4'd8:  s = '{strobe: 1'b1, nibble: 4'hC, wsel: WS_CMD};
				4'd9:  s = '{strobe: 1'b1, nibble: 4'h0, wsel: WS_ZERO};
				4'd10: s = '{strobe: 1'b1, nibble: 4'h6, wsel: WS_CMD};
				4'd11: s = '{strobe: 1'b1, nibble: 4'h0, wsel: WS_ZERO};
				default: s = '{strobe: 1'b1, nibble: 4'h1, wsel: WS_CMD_CLEAR};
			endcase
			return s;
		end
	endfunction

	function automatic logic [WaitW-1:0] sat_add(input logic [WaitW-1:0] a,
			input logic [WaitW-1:0] b);
		logic [WaitW:0] s;
		begin
			s = {1'b0, a} + {1'b0, b};
			return s[WaitW] ? {WaitW{1'b1}} : s[WaitW-1:0];
		end
	endfunction

endpackage

// File: sv/cln_if.sv
// Request, step and configuration channel interfaces.
interface cln_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] action;
	logic [7:0] data;
	logic [3:0] col;
	logic [2:0] row;
	logic [2:0] glyph_code;

	modport source (output valid, action, data, col, row, glyph_code, input ready);
	modport sink (input valid, action, data, col, row, glyph_code, output ready);
endinterface

interface cln_step_if;
	logic        valid;
	logic        ready;
	logic        strobe_res;
	logic        reg_select;
	logic [3:0]  nibble;
	logic [15:0] wait_us;
	logic        last;

	modport source (output valid, strobe_res, reg_select, nibble, wait_us, last,
		input ready);
	modport sink (input valid, strobe_res, reg_select, nibble, wait_us, last,
		output ready);
endinterface

interface cln_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] wdata;

	modport source (output valid, index, wdata, input ready);
	modport sink (input valid, index, wdata, output ready);
endinterface

// File: sv/cln_dpath.sv
// Datapath: wait registers, request byte, step formation and output register.
module cln_dpath (
	input  logic                 clk,
	input  logic                 arst_n,
	cln_req_if.sink              req,
	cln_step_if.source           step,
	cln_cfg_if.sink              cfg,
	input  cln_pkg::ctrl_cmd_t   cmd,
	output cln_pkg::dp_stat_t    stat
);

	logic [cln_pkg::WaitW-1:0] boot_q, rst1_q, rst2_q, rst3_q;
	logic [cln_pkg::WaitW-1:0] cmdw_q, dataw_q, clearw_q, homew_q;

	cln_pkg::action_t act_q;
	logic [7:0]       byte_q;

	cln_pkg::action_t          req_act;
	logic [7:0]                req_byte;
	cln_pkg::init_step_t       ini;
	logic                      nx_strobe;
	logic                      nx_rs;
	logic [3:0]                nx_nibble;
	cln_pkg::wsel_t            nx_wsel;
	logic [cln_pkg::WaitW-1:0] nx_wait;
	logic                      out_valid_q;

	assign cfg.ready = 1'b1;
	assign req_act = cln_pkg::action_t'(req.action);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boot_q   <= cln_pkg::RST_BOOT;
			rst1_q   <= cln_pkg::RST_RST1;
			rst2_q   <= cln_pkg::RST_RST2;
			rst3_q   <= cln_pkg::RST_RST3;
			cmdw_q   <= cln_pkg::RST_CMD;
			dataw_q  <= cln_pkg::RST_DATA;
			clearw_q <= cln_pkg::RST_CLEAR;
			homew_q  <= cln_pkg::RST_HOME;
		end else if (cfg.valid) begin
			unique case (cln_pkg::cfg_idx_t'(cfg.index))
				cln_pkg::CFG_BOOT:  boot_q   <= cfg.wdata;
				cln_pkg::CFG_RST1:  rst1_q   <= cfg.wdata;
				cln_pkg::CFG_RST2:  rst2_q   <= cfg.wdata;
				cln_pkg::CFG_RST3:  rst3_q   <= cfg.wdata;
				cln_pkg::CFG_CMD:   cmdw_q   <= cfg.wdata;
				cln_pkg::CFG_DATA:  dataw_q  <= cfg.wdata;
				cln_pkg::CFG_CLEAR: clearw_q <= cfg.wdata;
				default:            homew_q  <= cfg.wdata;
			endcase
		end
	end

	// Byte of the request and whether it yields any step
	always_comb begin
		req_byte      = req.data;
		stat.none     = 1'b0;
		stat.last_idx = cln_pkg::BYTE_LAST_IDX;
		stat.out_busy = out_valid_q && !step.ready;
		unique case (req.action)
			cln_pkg::ACT_INIT:   stat.last_idx = cln_pkg::INIT_LAST_IDX;
			cln_pkg::ACT_DATA,
			cln_pkg::ACT_CMD:    req_byte = req.data;
			cln_pkg::ACT_CLEAR:  req_byte = cln_pkg::CMD_CLEAR_CODE;
			cln_pkg::ACT_HOME:   req_byte = cln_pkg::CMD_HOME_CODE;
			cln_pkg::ACT_CURSOR: begin
				req_byte  = cln_pkg::CMD_DDRAM | cln_pkg::line_addr(req.row[1:0])
					| {4'h0, req.col};
				stat.none = req.row[2];
			end
			cln_pkg::ACT_GLYPH:  req_byte = cln_pkg::CMD_CGRAM | {2'b00, req.glyph_code, 3'b000};
			default:             stat.none = 1'b1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q  <= req_act;
			byte_q <= req_byte;
		end
	end

	// Step for the current index
	always_comb begin
		ini       = cln_pkg::init_step(cmd.idx);
		nx_strobe = 1'b1;
		nx_rs     = (act_q == cln_pkg::ACT_DATA);
		nx_nibble = cmd.idx[0] ? byte_q[3:0] : byte_q[7:4];
		nx_wsel   = cln_pkg::WS_ZERO;
		if (act_q == cln_pkg::ACT_INIT) begin
			nx_strobe = ini.strobe;
			nx_nibble = ini.nibble;
			nx_wsel   = ini.wsel;
		end else if (cmd.idx[0]) begin
			case (act_q)
				cln_pkg::ACT_DATA:  nx_wsel = cln_pkg::WS_DATA;
				cln_pkg::ACT_CLEAR: nx_wsel = cln_pkg::WS_CMD_CLEAR;
				cln_pkg::ACT_HOME:  nx_wsel = cln_pkg::WS_CMD_HOME;
				default:            nx_wsel = cln_pkg::WS_CMD;
			endcase
		end
	end

	always_comb begin
		unique case (nx_wsel)
			cln_pkg::WS_BOOT:      nx_wait = boot_q;
			cln_pkg::WS_RST1:      nx_wait = rst1_q;
			cln_pkg::WS_RST2:      nx_wait = rst2_q;
			cln_pkg::WS_RST3:      nx_wait = rst3_q;
			cln_pkg::WS_FOUR:      nx_wait = cln_pkg::FOUR_BIT_WAIT_US;
			cln_pkg::WS_CMD:       nx_wait = cmdw_q;
			cln_pkg::WS_DATA:      nx_wait = dataw_q;
			cln_pkg::WS_CMD_CLEAR: nx_wait = cln_pkg::sat_add(cmdw_q, clearw_q);
			cln_pkg::WS_CMD_HOME:  nx_wait = cln_pkg::sat_add(cmdw_q, homew_q);
			default:               nx_wait = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (step.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			step.strobe_res <= nx_strobe;
			step.reg_select <= nx_rs;
			step.nibble     <= nx_nibble;
			step.wait_us    <= nx_wait;
			step.last       <= cmd.last;
		end
	end

	assign step.valid = out_valid_q;

endmodule

// File: sv/cln_ctrl.sv
// Controller: takes a request and walks its steps into the output register.
module cln_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  cln_pkg::dp_stat_t  stat,
	output cln_pkg::ctrl_cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t                       state_q;
	logic [cln_pkg::StepIdxW-1:0] idx_q;
	logic [cln_pkg::StepIdxW-1:0] last_idx_q;

	assign req_ready = (state_q == ST_IDLE);
	assign cmd.load  = req_valid && req_ready;
	assign cmd.emit  = (state_q == ST_RUN) && !stat.out_busy;
	assign cmd.idx   = idx_q;
	assign cmd.last  = (idx_q == last_idx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			last_idx_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load && !stat.none) begin
						state_q    <= ST_RUN;
						idx_q      <= '0;
						last_idx_q <= stat.last_idx;
					end
				end
				default: begin
					if (cmd.emit) begin
						if (cmd.last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
			endcase
		end
	end

endmodule

// File: sv/char_lcd_nibble_sequencer.sv
// Top level of the character LCD nibble sequencer.
//
//   port  | role  | moves
//   ------+-------+---------------------------------------------
//   req   | sink  | one display request (action, data, col, row, glyph_code)
//   step  | source| one bus step (strobe_res, reg_select, nibble, wait_us, last)
//   cfg   | sink  | wait register write (index, wdata), always ready
//
// A request is taken, then its steps go out one per cycle while step is not stalled:
// 13 steps for init, 2 for every other action, none for action 7 or a
// cursor row of 4 or more. The next request is taken once the last step sits
// in the output register. A stall on step holds the step counter. Reset
// restores the wait defaults.
module char_lcd_nibble_sequencer (
	input logic        clk,
	input logic        arst_n,
	cln_req_if.sink    req,
	cln_step_if.source step,
	cln_cfg_if.sink    cfg
);

	cln_pkg::ctrl_cmd_t cmd;
	cln_pkg::dp_stat_t  stat;

	cln_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	cln_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.step   (step),
		.cfg    (cfg),
		.cmd    (cmd),
		.stat   (stat)
	);

endmodule
